// ===== hw/rtl/fdbds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbds_pkg: shared types and constants of the display scanner
// Register indexes, item kinds, configuration and result records, and the
// fixed-point reciprocals used to split a number into decimal digits.
// ----------------------------------------------------------------------------
package fdbds_pkg;

   localparam int unsigned NumWidth   = 16;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned NumDigits  = 4;
   localparam int unsigned PosWidth   = 2;
   localparam int unsigned ProdWidth  = 30;

   // Largest number that fits on four digits.
   localparam logic [NumWidth-1:0] MaxShown = 16'd9999;

   // Reciprocals of 10, 100 and 1000; exact for every value up to 9999.
   localparam logic [13:0] Recip10   = 14'd6554;
   localparam logic [13:0] Recip100  = 14'd5243;
   localparam logic [13:0] Recip1000 = 14'd8389;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_COMMON_ANODE    = 2'd0,
      CSR_DWELL_TICKS     = 2'd1,
      CSR_FRAMES_PER_LOAD = 2'd2
   } csr_index_type;

   // Kind of an input item.
   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_type;

   typedef struct packed {
      logic                  common_anode;
      logic [CountWidth-1:0] dwell_ticks;
      logic [CountWidth-1:0] frames_per_load;
   } cfg_type;

   typedef struct packed {
      logic                  status;
      logic [DigitWidth-1:0] bcd_code;
      logic [NumDigits-1:0]  common_levels;
      logic                  showing;
   } result_type;

endpackage

// ===== hw/rtl/fdbds_digit_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbds_digit_split: binary to four decimal digits
// Splits a number of at most 9999 into units, tens, hundreds and thousands
// with three parallel reciprocal multiplications, and flags larger numbers.
// ----------------------------------------------------------------------------
module fdbds_digit_split
   import fdbds_pkg::*;
(
   input  logic [NumWidth-1:0] number_i,
   output digits_type          digits_o,
   output logic                out_of_range_o
);

   logic [ProdWidth-1:0] prod10;
   logic [ProdWidth-1:0] prod100;
   logic [ProdWidth-1:0] prod1000;
   logic [9:0]           q10;
   logic [6:0]           q100;
   logic [3:0]           q1000;
   logic [NumWidth-1:0]  rem10;
   logic [NumWidth-1:0]  rem100;
   logic [NumWidth-1:0]  rem1000;

   // Quotients by 10, 100 and 1000, taken side by side.
   always_comb begin
      prod10   = ProdWidth'(number_i) * ProdWidth'(Recip10);
      prod100  = ProdWidth'(number_i) * ProdWidth'(Recip100);
      prod1000 = ProdWidth'(number_i) * ProdWidth'(Recip1000);
      q10      = prod10[25:16];
      q100     = prod100[25:19];
      q1000    = prod1000[26:23];
   end

   // Each lower digit is a quotient less ten times the next quotient; the thousands digit is the last quotient.
   always_comb begin
      rem10   = number_i - ((NumWidth'(q10) << 3) + (NumWidth'(q10) << 1));
      rem100  = NumWidth'(q10) - ((NumWidth'(q100) << 3) + (NumWidth'(q100) << 1));
      rem1000 = NumWidth'(q100) - ((NumWidth'(q1000) << 3) + (NumWidth'(q1000) << 1));
      digits_o[0]    = rem10[DigitWidth-1:0];
      digits_o[1]    = rem100[DigitWidth-1:0];
      digits_o[2]    = rem1000[DigitWidth-1:0];
      digits_o[3]    = q1000;
      out_of_range_o = (number_i > MaxShown);
   end

endmodule

// ===== hw/rtl/fdbds_scan_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdbds_scan_state: digit store, scan position, dwell and frame counters
// Applies one load or tick transaction to the scan state and forms the
// result from the state that follows it.
// ----------------------------------------------------------------------------
module fdbds_scan_state
   import fdbds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_i,
   input  action_type action_i,
   input  digits_type digits_i,
   input  logic       out_of_range_i,
   input  cfg_type    cfg_i,
   output result_type result_o
);

   digits_type            digit_store_ff, digit_store_in;
   logic [PosWidth-1:0]   scan_position_ff, scan_position_in;
   logic [CountWidth-1:0] dwell_count_ff, dwell_count_in;
   logic [CountWidth-1:0] frames_left_ff, frames_left_in;

   logic [CountWidth-1:0] limit;
   logic [CountWidth-1:0] count_inc;
   logic [NumDigits-1:0]  active;
   logic                  status;

   // Next state for one transaction.
   always_comb begin
      digit_store_in   = digit_store_ff;
      scan_position_in = scan_position_ff;
      dwell_count_in   = dwell_count_ff;
      frames_left_in   = frames_left_ff;
      status           = 1'b0;
      limit            = (cfg_i.dwell_ticks == '0) ? CountWidth'(1) : cfg_i.dwell_ticks;
      count_inc        = dwell_count_ff + CountWidth'(1);
      case (action_i)
         ACT_LOAD: begin
            if (out_of_range_i) begin
               status         = 1'b1;
               frames_left_in = '0;
            end else begin
               digit_store_in   = digits_i;
               scan_position_in = '0;
               dwell_count_in   = '0;
               frames_left_in   = cfg_i.frames_per_load;
            end
         end
         ACT_TICK: begin
            if (frames_left_ff != '0) begin
               if (count_inc >= limit) begin
                  dwell_count_in   = '0;
                  scan_position_in = scan_position_ff + PosWidth'(1);
                  if (scan_position_ff == PosWidth'(NumDigits - 1)) begin
                     frames_left_in = frames_left_ff - CountWidth'(1);
                  end
               end else begin
                  dwell_count_in = count_inc;
               end
            end
         end
         default: begin
            status = 1'b0;
         end
      endcase
   end

   // Result seen from the state after the transaction.
   always_comb begin
      result_o.status   = status;
      result_o.showing  = (frames_left_in != '0);
      active            = '0;
      result_o.bcd_code = '0;
      if (result_o.showing) begin
         active[scan_position_in] = 1'b1;
         result_o.bcd_code        = digit_store_in[scan_position_in];
      end
      result_o.common_levels = cfg_i.common_anode ? ~active : active;
   end

   // State registers; they move only when a transaction is applied.
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_store_ff   <= '0;
         scan_position_ff <= '0;
         dwell_count_ff   <= '0;
         frames_left_ff   <= '0;
      end else if (step_i) begin
         digit_store_ff   <= digit_store_in;
         scan_position_ff <= scan_position_in;
         dwell_count_ff   <= dwell_count_in;
         frames_left_ff   <= frames_left_in;
      end
   end

   // A tick never adds frames.
   assert property (@(posedge clock) disable iff (reset)
      (step_i && action_i == ACT_TICK) |=> (frames_left_ff <= $past(frames_left_ff)))
      else $error("frames_left grew on a tick");

   // Scan state holds between transactions.
   assert property (@(posedge clock) disable iff (reset)
      !step_i |=> ($stable(scan_position_ff) && $stable(dwell_count_ff)))
      else $error("scan state moved without a transaction");

   // A load in range restarts the scan at the units digit.
   assert property (@(posedge clock) disable iff (reset)
      (step_i && action_i == ACT_LOAD && !out_of_range_i)
      |=> (scan_position_ff == '0 && dwell_count_ff == '0))
      else $error("accepted load did not restart the scan");

endmodule

// ===== hw/rtl/four_digit_bcd_display_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_bcd_display_scanner: multiplexed four-digit display driver
// Loads a number, splits it into BCD digits and scans them onto four
// commons under a tick-driven dwell counter for a set number of frames.
// ----------------------------------------------------------------------------
// Usage:
// Each req transaction is a load (req_tuser 0, number in req_tdata) or a
// time tick (req_tuser 1). Every transaction yields exactly one rsp
// transaction carrying the display levels after it: the BCD code for the
// external decoder, the four common pin levels with polarity applied, a
// showing flag, and in rsp_tuser an out-of-range flag for loads above 9999.
// The csr port writes common polarity, dwell ticks and frames per load; the
// user must write it only while no transaction is in flight; the block
// does not enforce this. Each transaction passes one input register and
// one result register around a single pass of logic (three parallel
// reciprocal multiplies feed the digit split). Throughput: one
// transaction per cycle while rsp_tready stays high. The input register is
// refilled while a result waits, so a stalled rsp side holds at most two
// transactions before req_tready drops; nothing is lost or repeated.
// Reset clears the digits, blanks the display, and restores the register
// defaults: common cathode, dwell of one tick and fifty frames per load.
// ----------------------------------------------------------------------------
module four_digit_bcd_display_scanner
   import fdbds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [NumWidth-1:0]   req_tdata,   // [15:0] number
   input  logic                  req_tuser,   // [0] action
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [3:0] bcd_code, [7:4] common_levels,
                                              // [8] showing, [15:9] zero
   output logic                  rsp_tuser,   // [0] status
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CountWidth-1:0] csr_wdata
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff, in_valid_in;
   action_type            in_action_ff;
   logic [NumWidth-1:0]   in_number_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_result_ff;
   result_type            result;
   digits_type            digits;
   logic                  out_of_range;
   logic                  req_accept;
   logic                  advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.common_anode    <= 1'b0;
         cfg_ff.dwell_ticks     <= CountWidth'(1);
         cfg_ff.frames_per_load <= CountWidth'(50);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COMMON_ANODE:    cfg_ff.common_anode    <= csr_wdata[0];
            CSR_DWELL_TICKS:     cfg_ff.dwell_ticks     <= csr_wdata;
            CSR_FRAMES_PER_LOAD: cfg_ff.frames_per_load <= csr_wdata;
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result slot frees.
   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || !rsp_valid_ff || rsp_tready;
      req_accept   = req_tvalid && req_tready;
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= action_type'(req_tuser);
         in_number_ff <= req_tdata;
      end
   end

   fdbds_digit_split u_digit_split (
      .number_i       (in_number_ff),
      .digits_o       (digits),
      .out_of_range_o (out_of_range)
   );

   fdbds_scan_state u_scan_state (
      .clock          (clock),
      .reset          (reset),
      .step_i         (advance),
      .action_i       (in_action_ff),
      .digits_i       (digits),
      .out_of_range_i (out_of_range),
      .cfg_i          (cfg_ff),
      .result_o       (result)
   );

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.status;
   assign rsp_tdata  = {7'd0, rsp_result_ff.showing, rsp_result_ff.common_levels,
                        rsp_result_ff.bcd_code};

   // While showing, exactly one common is active under the set polarity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8])
      |-> $onehot(rsp_tdata[7:4] ^ {NumDigits{cfg_ff.common_anode}}))
      else $error("active common is not one-hot while showing");

   // A blanked display drives every common inactive and a zero code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[8])
      |-> (rsp_tdata[7:4] == {NumDigits{cfg_ff.common_anode}} && rsp_tdata[3:0] == '0))
      else $error("blanked display still drives a digit");

   // An out-of-range load always blanks the display.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[8])
      else $error("out-of-range load left the display showing");

endmodule
